// ----- src/acp_pkg.sv -----
// ---------------------------------------------------------------------------
// acp_pkg: shared types, codes and AES helper functions
// Holds the command record passed from the front end to the cipher core, the
// configuration codes, and the byte-level AES round functions.
// ---------------------------------------------------------------------------
package acp_pkg;

  localparam logic [2:0] CFG_KEY0   = 3'd0;
  localparam logic [2:0] CFG_KEY1   = 3'd1;
  localparam logic [2:0] CFG_KEY2   = 3'd2;
  localparam logic [2:0] CFG_KEY3   = 3'd3;
  localparam logic [2:0] CFG_IV_HI  = 3'd4;
  localparam logic [2:0] CFG_IV_LO  = 3'd5;
  localparam logic [2:0] CFG_MODE   = 3'd6;
  localparam logic [2:0] CFG_PAD_EN = 3'd7;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_PAD = 2'd1;
  localparam logic [1:0] STAT_PARTIAL = 2'd2;

  localparam logic [3:0] LAST_ROUND = 4'd14;

  typedef enum logic [1:0] {K_ERR, K_ZERO, K_ENC, K_DEC} acp_kind_t;

  typedef enum logic [1:0] {S_IDLE, S_KEXP, S_RUN, S_FIN} acp_state_t;

  typedef struct packed {
    logic [127:0] data;
    acp_kind_t    kind;
    logic         last;
    logic         extra;
    logic         chk;
  } acp_cmd_t;

  typedef struct packed {
    logic [255:0] key;
    logic [127:0] iv;
    logic         key_wr;
    logic         iv_hi_wr;
    logic         iv_lo_wr;
  } acp_keycfg_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = SBOX[s[127-8*i -: 8]];
    end
    sub_bytes = t;
  endfunction

  function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = INV_SBOX[s[127-8*i -: 8]];
    end
    inv_sub_bytes = t;
  endfunction

  // Byte 4c+r sits in column c, row r.
  function automatic logic [127:0] shift_rows(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+r)&3)+r) -: 8];
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*((c+r)&3)+r) -: 8] = s[127-8*(4*c+r) -: 8];
      end
    end
    inv_shift_rows = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_columns = t;
  endfunction

  function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
    logic [127:0]    t;
    logic [3:0][7:0] a, x2, x4, x8, m9, m11, m13, m14;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]   = s[127-32*c-8*r -: 8];
        x2[r]  = xtime(a[r]);
        x4[r]  = xtime(x2[r]);
        x8[r]  = xtime(x4[r]);
        m9[r]  = x8[r] ^ a[r];
        m11[r] = x8[r] ^ x2[r] ^ a[r];
        m13[r] = x8[r] ^ x4[r] ^ a[r];
        m14[r] = x8[r] ^ x4[r] ^ x2[r];
      end
      t[127-32*c -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      t[119-32*c -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      t[111-32*c -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      t[103-32*c -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    inv_mix_columns = t;
  endfunction

endpackage

// ----- src/acp_front.sv -----
// ---------------------------------------------------------------------------
// acp_front: input classification and command queue
// Sorts each incoming beat into a cipher job or a direct result, fills in
// the PKCS#7 pad bytes, and holds up to two commands for the core.
// ---------------------------------------------------------------------------
module acp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [63:0]       in_data_high,
  input  logic [63:0]       in_data_low,
  input  logic [4:0]        in_valid_bytes_in,
  input  logic              in_is_last,
  input  logic              mode,
  input  logic              pad_en,
  output acp_pkg::acp_cmd_t cmd,
  output logic              cmd_valid,
  input  logic              cmd_pop
);

  acp_pkg::acp_cmd_t q_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  acp_pkg::acp_cmd_t new_cmd;
  logic [127:0]      padded;
  logic [7:0]        pad_byte;
  logic              push;
  logic              full_blk;
  logic              bad_enc;

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  assign pad_byte = {3'd0, 5'd16 - in_valid_bytes_in};
  assign full_blk = (in_valid_bytes_in == 5'd16);

  // Bytes at and past the count take the pad value; a full block is unchanged.
  always_comb begin
    padded = {in_data_high, in_data_low};
    for (int i = 0; i < 16; i++) begin
      if (5'(i) >= in_valid_bytes_in) begin
        padded[127-8*i -: 8] = pad_byte;
      end
    end
  end

  assign bad_enc = (in_valid_bytes_in > 5'd16) || (!in_is_last && !full_blk) ||
                   (in_is_last && !pad_en && !full_blk && in_valid_bytes_in != 5'd0);

  always_comb begin
    new_cmd.data  = padded;
    new_cmd.last  = in_is_last;
    new_cmd.extra = 1'b0;
    new_cmd.chk   = 1'b0;
    new_cmd.kind  = acp_pkg::K_ERR;
    if (mode) begin
      if (full_blk) begin
        new_cmd.kind = acp_pkg::K_DEC;
        new_cmd.chk  = in_is_last && pad_en;
      end
    end else if (!bad_enc) begin
      if (full_blk) begin
        new_cmd.kind  = acp_pkg::K_ENC;
        new_cmd.extra = in_is_last && pad_en;
      end else if (!pad_en) begin
        new_cmd.kind = acp_pkg::K_ZERO;
      end else begin
        new_cmd.kind = acp_pkg::K_ENC;
      end
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ----- src/acp_core.sv -----
// ---------------------------------------------------------------------------
// acp_core: iterative AES-256 CBC core
// Expands the key once after each key change, runs one AES round per cycle,
// keeps the chaining value, checks padding and drives the result register.
// ---------------------------------------------------------------------------
module acp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acp_pkg::acp_cmd_t    cmd,
  input  logic                 cmd_valid,
  output logic                 cmd_pop,
  input  acp_pkg::acp_keycfg_t kcfg,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          out_high,
  output logic [63:0]          out_low,
  output logic [4:0]           out_valid_bytes_out,
  output logic                 out_last_out,
  output logic [1:0]           out_status
);

  acp_pkg::acp_state_t state_r, state_nxt;

  logic [127:0] rk_r [15];
  logic         rk_we;
  logic [127:0] rk_wdata;
  logic [127:0] ka_r, ka_nxt, kb_r, kb_nxt, knew;
  logic [3:0]   kstep_r, kstep_nxt;
  logic         keys_ok_r, keys_ok_nxt;

  logic [127:0] s_r, s_nxt, ct_r, ct_nxt, chain_r, chain_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         dec_r, dec_nxt, last_r, last_nxt, extra_r, extra_nxt, chk_r, chk_nxt;

  logic [127:0] od_r, od_nxt;
  logic [4:0]   ovb_r, ovb_nxt;
  logic         olast_r, olast_nxt, ovalid_r, ovalid_nxt;
  logic [1:0]   ostat_r, ostat_nxt;
  logic         out_free;

  logic [3:0]   key_idx;
  logic [127:0] rk_cur, enc_t, dec_t, round_out, res;
  logic [31:0]  ktemp;
  logic [7:0]   rcon;
  logic [7:0]   p;
  logic         pad_ok;

  assign out_free = !ovalid_r || !out_stall;

  // Key expansion, four words per step; even steps rotate and add rcon.
  assign rcon  = 8'h01 << (kstep_r[3:1] - 3'd1);
  assign ktemp = kstep_r[0] ? acp_pkg::sub_word(kb_r[31:0])
               : acp_pkg::sub_word({kb_r[23:0], kb_r[31:24]}) ^ {rcon, 24'd0};
  always_comb begin
    knew[127:96] = ka_r[127:96] ^ ktemp;
    knew[95:64]  = ka_r[95:64] ^ knew[127:96];
    knew[63:32]  = ka_r[63:32] ^ knew[95:64];
    knew[31:0]   = ka_r[31:0] ^ knew[63:32];
  end
  always_comb begin
    if (kstep_r == 4'd0) begin
      rk_wdata = kcfg.key[255:128];
    end else if (kstep_r == 4'd1) begin
      rk_wdata = kcfg.key[127:0];
    end else begin
      rk_wdata = knew;
    end
  end

  // Decryption walks the schedule backwards.
  assign key_idx   = dec_r ? acp_pkg::LAST_ROUND - rnd_r : rnd_r;
  assign rk_cur    = rk_r[key_idx];
  assign enc_t     = acp_pkg::shift_rows(acp_pkg::sub_bytes(s_r));
  assign dec_t     = acp_pkg::inv_sub_bytes(acp_pkg::inv_shift_rows(s_r)) ^ rk_cur;
  always_comb begin
    if (dec_r) begin
      round_out = (rnd_r == acp_pkg::LAST_ROUND) ? dec_t : acp_pkg::inv_mix_columns(dec_t);
    end else begin
      round_out = ((rnd_r == acp_pkg::LAST_ROUND) ? enc_t : acp_pkg::mix_columns(enc_t))
                  ^ rk_cur;
    end
  end

  assign res = dec_r ? (s_r ^ chain_r) : s_r;
  assign p   = res[7:0];
  always_comb begin
    pad_ok = (p != 8'd0) && (p <= 8'd16);
    for (int i = 0; i < 16; i++) begin
      if (({1'b0, 5'(i)} + {1'b0, p[4:0]}) >= 6'd16 && res[127-8*i -: 8] != p) begin
        pad_ok = 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      acp_pkg::S_IDLE: begin
        if (cmd_valid) begin
          if (!keys_ok_r) begin
            state_nxt = acp_pkg::S_KEXP;
          end else if (cmd.kind == acp_pkg::K_ENC || cmd.kind == acp_pkg::K_DEC) begin
            state_nxt = acp_pkg::S_RUN;
          end
        end
      end
      acp_pkg::S_KEXP: begin
        if (kstep_r == acp_pkg::LAST_ROUND) begin
          state_nxt = acp_pkg::S_IDLE;
        end
      end
      acp_pkg::S_RUN: begin
        if (rnd_r == acp_pkg::LAST_ROUND) begin
          state_nxt = acp_pkg::S_FIN;
        end
      end
      acp_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = (!dec_r && extra_r) ? acp_pkg::S_RUN : acp_pkg::S_IDLE;
        end
      end
      default: state_nxt = acp_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cmd_pop     = 1'b0;
    rk_we       = 1'b0;
    ka_nxt      = ka_r;
    kb_nxt      = kb_r;
    kstep_nxt   = kstep_r;
    keys_ok_nxt = keys_ok_r;
    s_nxt       = s_r;
    ct_nxt      = ct_r;
    chain_nxt   = chain_r;
    rnd_nxt     = rnd_r;
    dec_nxt     = dec_r;
    last_nxt    = last_r;
    extra_nxt   = extra_r;
    chk_nxt     = chk_r;
    od_nxt      = od_r;
    ovb_nxt     = ovb_r;
    olast_nxt   = olast_r;
    ostat_nxt   = ostat_r;
    ovalid_nxt  = ovalid_r && out_stall;

    unique case (state_r)
      acp_pkg::S_IDLE: begin
        if (cmd_valid && !keys_ok_r) begin
          kstep_nxt = 4'd0;
        end else if (cmd_valid) begin
          dec_nxt   = (cmd.kind == acp_pkg::K_DEC);
          last_nxt  = cmd.last;
          extra_nxt = cmd.extra;
          chk_nxt   = cmd.chk;
          rnd_nxt   = 4'd1;
          ct_nxt    = cmd.data;
          case (cmd.kind)
            acp_pkg::K_ENC: begin
              s_nxt   = cmd.data ^ chain_r ^ rk_r[0];
              cmd_pop = 1'b1;
            end
            acp_pkg::K_DEC: begin
              s_nxt   = cmd.data ^ rk_r[14];
              cmd_pop = 1'b1;
            end
            default: begin
              if (out_free) begin
                cmd_pop    = 1'b1;
                ovalid_nxt = 1'b1;
                od_nxt     = '0;
                ovb_nxt    = 5'd0;
                olast_nxt  = cmd.last;
                ostat_nxt  = (cmd.kind == acp_pkg::K_ERR) ? acp_pkg::STAT_PARTIAL
                                                          : acp_pkg::STAT_OK;
                if (cmd.last) begin
                  chain_nxt = kcfg.iv;
                end
              end
            end
          endcase
        end
      end
      acp_pkg::S_KEXP: begin
        rk_we     = 1'b1;
        ka_nxt    = kb_r;
        kb_nxt    = rk_wdata;
        kstep_nxt = kstep_r + 4'd1;
        if (kstep_r == acp_pkg::LAST_ROUND) begin
          keys_ok_nxt = 1'b1;
        end
      end
      acp_pkg::S_RUN: begin
        s_nxt   = round_out;
        rnd_nxt = rnd_r + 4'd1;
      end
      acp_pkg::S_FIN: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          od_nxt     = res;
          ovb_nxt    = 5'd16;
          olast_nxt  = last_r;
          ostat_nxt  = acp_pkg::STAT_OK;
          if (!dec_r) begin
            if (extra_r) begin
              // Full final block with padding: a whole pad block follows.
              olast_nxt = 1'b0;
              chain_nxt = s_r;
              s_nxt     = {16{8'h10}} ^ s_r ^ rk_r[0];
              extra_nxt = 1'b0;
              rnd_nxt   = 4'd1;
            end else begin
              chain_nxt = last_r ? kcfg.iv : s_r;
            end
          end else begin
            chain_nxt = last_r ? kcfg.iv : ct_r;
            if (chk_r) begin
              if (pad_ok) begin
                ovb_nxt = 5'd16 - p[4:0];
              end else begin
                od_nxt    = '0;
                ovb_nxt   = 5'd0;
                ostat_nxt = acp_pkg::STAT_BAD_PAD;
              end
            end
          end
        end
      end
      default: ;
    endcase

    if (kcfg.key_wr) begin
      keys_ok_nxt = 1'b0;
    end
    if (kcfg.iv_hi_wr) begin
      chain_nxt[127:64] = kcfg.iv[127:64];
    end
    if (kcfg.iv_lo_wr) begin
      chain_nxt[63:0] = kcfg.iv[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= acp_pkg::S_IDLE;
      keys_ok_r <= 1'b0;
      ovalid_r  <= 1'b0;
      chain_r   <= '0;
      kstep_r   <= 4'd0;
      rnd_r     <= 4'd0;
      dec_r     <= 1'b0;
      extra_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      keys_ok_r <= keys_ok_nxt;
      ovalid_r  <= ovalid_nxt;
      chain_r   <= chain_nxt;
      kstep_r   <= kstep_nxt;
      rnd_r     <= rnd_nxt;
      dec_r     <= dec_nxt;
      extra_r   <= extra_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ka_r    <= ka_nxt;
    kb_r    <= kb_nxt;
    s_r     <= s_nxt;
    ct_r    <= ct_nxt;
    last_r  <= last_nxt;
    chk_r   <= chk_nxt;
    od_r    <= od_nxt;
    ovb_r   <= ovb_nxt;
    olast_r <= olast_nxt;
    ostat_r <= ostat_nxt;
    if (rk_we) begin
      rk_r[kstep_r] <= rk_wdata;
    end
  end

  assign out_valid           = ovalid_r;
  assign out_high            = od_r[127:64];
  assign out_low             = od_r[63:0];
  assign out_valid_bytes_out = ovb_r;
  assign out_last_out        = olast_r;
  assign out_status          = ostat_r;

endmodule

// ----- src/aes256_cbc_pkcs7_engine_top.sv -----
// ---------------------------------------------------------------------------
// aes256_cbc_pkcs7_engine_top: AES-256 CBC engine with PKCS#7 padding
// Input beats carry one 16-byte block with a byte count and a last mark;
// output beats carry result blocks with byte count, last mark and status.
//
// Both channels use valid/stall. A two-entry command queue sits behind the
// input, so new beats are taken while the core works and while a result
// waits in the output register. Key, IV, direction and padding are written
// through the cfg port; the user must write them only while the engine is
// idle; the block does not enforce it. An IV write also reloads that half
// of the chaining value. A cipher block passes through the core as a start
// step, 14 rounds on a single shared round unit, and a step that chains and
// writes the result. The core takes one block at a time and starts the next
// only after the result is written. A full final encrypt block with padding
// yields two results. Error and empty results skip the rounds. The first
// block after reset or after any key write is preceded by key expansion.
// Reset clears the chain to zero, sets padding on and empties the queue. A
// stalled result holds; the queue then fills and the input stalls.
// ---------------------------------------------------------------------------
module aes256_cbc_pkcs7_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_high,
  input  logic [63:0] in_data_low,
  input  logic [4:0]  in_valid_bytes_in,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  output logic [4:0]  out_valid_bytes_out,
  output logic        out_last_out,
  output logic [1:0]  out_status
);

  logic [63:0] key0_r, key1_r, key2_r, key3_r, iv_hi_r, iv_lo_r;
  logic        mode_r, pad_en_r;

  acp_pkg::acp_cmd_t    cmd;
  logic                 cmd_valid;
  logic                 cmd_pop;
  acp_pkg::acp_keycfg_t kcfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r   <= '0;
      key1_r   <= '0;
      key2_r   <= '0;
      key3_r   <= '0;
      iv_hi_r  <= '0;
      iv_lo_r  <= '0;
      mode_r   <= 1'b0;
      pad_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        acp_pkg::CFG_KEY0:   key0_r   <= cfg_data;
        acp_pkg::CFG_KEY1:   key1_r   <= cfg_data;
        acp_pkg::CFG_KEY2:   key2_r   <= cfg_data;
        acp_pkg::CFG_KEY3:   key3_r   <= cfg_data;
        acp_pkg::CFG_IV_HI:  iv_hi_r  <= cfg_data;
        acp_pkg::CFG_IV_LO:  iv_lo_r  <= cfg_data;
        acp_pkg::CFG_MODE:   mode_r   <= cfg_data[0];
        acp_pkg::CFG_PAD_EN: pad_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The core sees the IV in the cycle after the write, together with the strobe.
  logic key_wr_r, iv_hi_wr_r, iv_lo_wr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_wr_r   <= 1'b0;
      iv_hi_wr_r <= 1'b0;
      iv_lo_wr_r <= 1'b0;
    end else begin
      key_wr_r   <= cfg_we && (cfg_idx == acp_pkg::CFG_KEY0 || cfg_idx == acp_pkg::CFG_KEY1 ||
                               cfg_idx == acp_pkg::CFG_KEY2 || cfg_idx == acp_pkg::CFG_KEY3);
      iv_hi_wr_r <= cfg_we && (cfg_idx == acp_pkg::CFG_IV_HI);
      iv_lo_wr_r <= cfg_we && (cfg_idx == acp_pkg::CFG_IV_LO);
    end
  end

  always_comb begin
    kcfg.key      = {key0_r, key1_r, key2_r, key3_r};
    kcfg.iv       = {iv_hi_r, iv_lo_r};
    kcfg.key_wr   = key_wr_r;
    kcfg.iv_hi_wr = iv_hi_wr_r;
    kcfg.iv_lo_wr = iv_lo_wr_r;
  end

  acp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_high      (in_data_high),
    .in_data_low       (in_data_low),
    .in_valid_bytes_in (in_valid_bytes_in),
    .in_is_last        (in_is_last),
    .mode              (mode_r),
    .pad_en            (pad_en_r),
    .cmd               (cmd),
    .cmd_valid         (cmd_valid),
    .cmd_pop           (cmd_pop)
  );

  acp_core u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cmd_valid           (cmd_valid),
    .cmd_pop             (cmd_pop),
    .kcfg                (kcfg),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_high            (out_high),
    .out_low             (out_low),
    .out_valid_bytes_out (out_valid_bytes_out),
    .out_last_out        (out_last_out),
    .out_status          (out_status)
  );

endmodule

// ----- test/aes256_cbc_pkcs7_engine_top_tb.sv -----
// ---------------------------------------------------------------------------
// aes256_cbc_pkcs7_engine_top_tb: self-checking bench for the AES-256 CBC engine
// Feeds messages of 16-byte beats in both directions, with and without PKCS#7
// padding, plus malformed beats. An independent AES-256 CBC predictor builds
// the expected result beats, and each output beat is compared field by field.
// ---------------------------------------------------------------------------
module aes256_cbc_pkcs7_engine_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  vb;
    logic        last;
  } blk_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  vb;
    logic        last;
    logic [1:0]  st;
  } res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = acp_pkg::CFG_KEY0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_data_high = '0;
  logic [63:0] in_data_low = '0;
  logic [4:0]  in_valid_bytes_in = '0;
  logic        in_is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic [4:0]  out_valid_bytes_out;
  logic        out_last_out;
  logic [1:0]  out_status;

  aes256_cbc_pkcs7_engine_top u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state, kept apart from the engine.
  logic [7:0]   sb [256];
  logic [7:0]   isb [256];
  logic [63:0]  key_r [4];
  logic [63:0]  iv_hi_r, iv_lo_r;
  logic         mode_r, pad_r;
  logic [127:0] chain_r;
  logic [31:0]  w [60];

  blk_t block_q [$];
  res_t result_q [$];
  int   n_fail, n_sent, n_res, n_msgs, n_pad_err, n_part_err;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // S-box from the field inverse and the affine map.
  function automatic void build_sbox();
    logic [7:0] inv, x;
    for (int v = 0; v < 256; v++) begin
      inv = 8'h00;
      for (int u = 1; u < 256; u++) begin
        if (gf_mul(v[7:0], u[7:0]) == 8'h01) inv = u[7:0];
      end
      x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sb[v] = x;
      isb[x] = v[7:0];
    end
  endfunction

  function automatic void expand_key();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) w[i] = (i % 2) ? key_r[i/2][31:0] : key_r[i/2][63:32];
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sb[t[31:24]] ^ rc, sb[t[23:16]], sb[t[15:8]], sb[t[7:0]]};
        rc = gf_mul(rc, 8'h02);
      end else if (i % 8 == 4) begin
        t = {sb[t[31:24]], sb[t[23:16]], sb[t[15:8]], sb[t[7:0]]};
      end
      w[i] = w[i-8] ^ t;
    end
  endfunction

  function automatic logic [127:0] rkey(int r);
    return {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] aes_enc(logic [127:0] x);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [127:0] v;
    v = x ^ rkey(0);
    for (int rnd = 1; rnd <= 14; rnd++) begin
      for (int i = 0; i < 16; i++) s[i] = sb[v[127-8*i -: 8]];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[4*c+r] = s[4*((c+r)%4)+r];
      for (int c = 0; c < 4; c++) begin
        if (rnd != 14) begin
          s[4*c]   = gf_mul(t[4*c],2) ^ gf_mul(t[4*c+1],3) ^ t[4*c+2] ^ t[4*c+3];
          s[4*c+1] = t[4*c] ^ gf_mul(t[4*c+1],2) ^ gf_mul(t[4*c+2],3) ^ t[4*c+3];
          s[4*c+2] = t[4*c] ^ t[4*c+1] ^ gf_mul(t[4*c+2],2) ^ gf_mul(t[4*c+3],3);
          s[4*c+3] = gf_mul(t[4*c],3) ^ t[4*c+1] ^ t[4*c+2] ^ gf_mul(t[4*c+3],2);
        end else begin
          for (int r = 0; r < 4; r++) s[4*c+r] = t[4*c+r];
        end
      end
      for (int i = 0; i < 16; i++) v[127-8*i -: 8] = s[i];
      v ^= rkey(rnd);
    end
    return v;
  endfunction

  function automatic logic [127:0] aes_dec(logic [127:0] x);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [127:0] v;
    v = x ^ rkey(14);
    for (int rnd = 14; rnd >= 1; rnd--) begin
      for (int i = 0; i < 16; i++) s[i] = v[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[4*((c+r)%4)+r] = s[4*c+r];
      for (int i = 0; i < 16; i++) v[127-8*i -: 8] = isb[t[i]];
      v ^= rkey(rnd - 1);
      if (rnd != 1) begin
        for (int i = 0; i < 16; i++) t[i] = v[127-8*i -: 8];
        for (int c = 0; c < 4; c++) begin
          s[4*c]   = gf_mul(t[4*c],14) ^ gf_mul(t[4*c+1],11) ^ gf_mul(t[4*c+2],13)
                     ^ gf_mul(t[4*c+3],9);
          s[4*c+1] = gf_mul(t[4*c],9) ^ gf_mul(t[4*c+1],14) ^ gf_mul(t[4*c+2],11)
                     ^ gf_mul(t[4*c+3],13);
          s[4*c+2] = gf_mul(t[4*c],13) ^ gf_mul(t[4*c+1],9) ^ gf_mul(t[4*c+2],14)
                     ^ gf_mul(t[4*c+3],11);
          s[4*c+3] = gf_mul(t[4*c],11) ^ gf_mul(t[4*c+1],13) ^ gf_mul(t[4*c+2],9)
                     ^ gf_mul(t[4*c+3],14);
        end
        for (int i = 0; i < 16; i++) v[127-8*i -: 8] = s[i];
      end
    end
    return v;
  endfunction

  function automatic void expect_beat(logic [127:0] d, logic [4:0] vb, logic last,
                                      logic [1:0] st);
    res_t e;
    e.hi = d[127:64]; e.lo = d[63:0]; e.vb = vb; e.last = last; e.st = st;
    result_q.push_back(e);
  endfunction

  // Expected result beats for one accepted input beat.
  function automatic void cbc_step(blk_t b);
    logic [127:0] d, c, p;
    logic [7:0]   pv;
    logic         bad;
    expand_key();
    d = {b.hi, b.lo};
    if (mode_r == MODE_ENC) begin
      bad = b.vb > 16 || (!b.last && b.vb != 16) ||
            (b.last && !pad_r && b.vb != 16 && b.vb != 0);
      if (bad) begin
        expect_beat('0, 0, b.last, acp_pkg::STAT_PARTIAL);
        n_part_err++;
      end else if (!b.last || b.vb == 16) begin
        c = aes_enc(d ^ chain_r);
        chain_r = c;
        if (!b.last || !pad_r) begin
          expect_beat(c, 16, b.last, acp_pkg::STAT_OK);
        end else begin
          expect_beat(c, 16, 1'b0, acp_pkg::STAT_OK);
          expect_beat(aes_enc({16{8'h10}} ^ chain_r), 16, 1'b1, acp_pkg::STAT_OK);
        end
      end else if (!pad_r) begin
        expect_beat('0, 0, 1'b1, acp_pkg::STAT_OK);
      end else begin
        for (int i = 0; i < 16; i++)
          if (i >= b.vb) d[127-8*i -: 8] = 8'(16 - b.vb);
        expect_beat(aes_enc(d ^ chain_r), 16, 1'b1, acp_pkg::STAT_OK);
      end
    end else if (b.vb != 16) begin
      expect_beat('0, 0, b.last, acp_pkg::STAT_PARTIAL);
      n_part_err++;
    end else begin
      p = aes_dec(d) ^ chain_r;
      chain_r = d;
      if (!b.last || !pad_r) begin
        expect_beat(p, 16, b.last, acp_pkg::STAT_OK);
      end else begin
        pv = p[7:0];
        bad = pv == 0 || pv > 16;
        for (int i = 0; i < 16; i++)
          if (!bad && i >= 16 - pv && p[127-8*i -: 8] != pv) bad = 1'b1;
        if (bad) begin
          expect_beat('0, 0, 1'b1, acp_pkg::STAT_BAD_PAD);
          n_pad_err++;
        end else begin
          expect_beat(p, 5'(16 - pv), 1'b1, acp_pkg::STAT_OK);
        end
      end
    end
    if (b.last) chain_r = {iv_hi_r, iv_lo_r};
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      acp_pkg::CFG_KEY0, acp_pkg::CFG_KEY1, acp_pkg::CFG_KEY2, acp_pkg::CFG_KEY3:
        key_r[idx] = data;
      acp_pkg::CFG_IV_HI: begin iv_hi_r = data; chain_r[127:64] = data; end
      acp_pkg::CFG_IV_LO: begin iv_lo_r = data; chain_r[63:0] = data; end
      acp_pkg::CFG_MODE: mode_r = data[0];
      acp_pkg::CFG_PAD_EN: pad_r = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic void push_blk(logic [127:0] d, logic [4:0] vb, logic last);
    blk_t b;
    b.hi = d[127:64]; b.lo = d[63:0]; b.vb = vb; b.last = last;
    block_q.push_back(b);
  endfunction

  // One message under the current settings. For decryption the ciphertext is
  // built from a padded plaintext so the padding check can pass; a corrupted
  // tail byte can break it.
  function automatic void push_msg(int nfull, int tail, bit corrupt);
    logic [127:0] d, ch;
    n_msgs++;
    ch = {iv_hi_r, iv_lo_r};
    expand_key();
    for (int k = 0; k <= nfull; k++) begin
      d = {rnd64(), rnd64()};
      if (mode_r == MODE_ENC) begin
        push_blk(d, (k == nfull) ? 5'(tail) : 5'd16, k == nfull);
      end else begin
        if (k == nfull && pad_r) begin
          for (int i = 0; i < 16; i++)
            if (i >= tail) d[127-8*i -: 8] = 8'(16 - tail);
          if (corrupt) d[7:0] = ($urandom_range(0, 1)) ? 8'h00 : 8'($urandom);
        end
        ch = aes_enc(d ^ ch);
        push_blk(ch, 16, k == nfull);
      end
    end
  endfunction

  task automatic drain();
    @(negedge clk);
    while (block_q.size() > 0 || in_valid || result_q.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Sender: one beat held until taken, random gaps between beats.
  int   gap;
  blk_t cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        cbc_step(cur);
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (block_q.size() > 0) begin
          cur = block_q.pop_front();
          in_valid <= 1'b1;
          in_data_high <= cur.hi;
          in_data_low <= cur.lo;
          in_valid_bytes_in <= cur.vb;
          in_is_last <= cur.last;
          case ($urandom_range(0, 19))
            0: gap = $urandom_range(10, 40);
            1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
            default: gap = 0;
          endcase
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
    n_fail++;
    $display("%0t mismatch on %s: got %h want %h", $realtime, what, got, want);
  endtask

  // Receiver: checks each taken beat, stalls in bursts.
  int stall_run, stall_pct;
  res_t e;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_res++;
      if (result_q.size() == 0) begin
        report_mismatch("unexpected beat", {out_high, out_low}, '0);
      end else begin
        e = result_q.pop_front();
        if ({out_high, out_low} != {e.hi, e.lo})
          report_mismatch("block", {out_high, out_low}, {e.hi, e.lo});
        if (out_valid_bytes_out != e.vb)
          report_mismatch("valid bytes", out_valid_bytes_out, e.vb);
        if (out_last_out != e.last) report_mismatch("last", out_last_out, e.last);
        if (out_status != e.st) report_mismatch("status", out_status, e.st);
      end
    end
    if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_pct = $urandom_range(0, 2) * 30;
      if ($urandom_range(0, 99) == 0) stall_run = $urandom_range(10, 40);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d result beats outstanding", result_q.size());
    $display("[aes256_cbc_pkcs7_engine_top] ERROR");
    $finish;
  end

  initial begin
    int nfull, tail;
    build_sbox();
    for (int i = 0; i < 4; i++) key_r[i] = '0;
    iv_hi_r = '0; iv_lo_r = '0; mode_r = MODE_ENC; pad_r = 1'b1; chain_r = '0;
    stall_pct = 0;
    stall_run = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero key and IV, encrypt, padding on.
    push_blk('0, 16, 1'b1);
    push_blk('1, 16, 1'b0);
    push_blk('1, 0, 1'b1);
    push_blk({rnd64(), rnd64()}, 15, 1'b1);
    push_blk({rnd64(), rnd64()}, 1, 1'b1);
    push_blk({rnd64(), rnd64()}, 17, 1'b0);
    push_blk({rnd64(), rnd64()}, 5, 1'b0);
    push_blk({rnd64(), rnd64()}, 31, 1'b1);
    drain();

    // All-ones key and IV, padding off.
    for (int i = 0; i < 6; i++) cfg_write(3'(i), '1);
    cfg_write(acp_pkg::CFG_PAD_EN, 64'd0);
    push_blk({rnd64(), rnd64()}, 16, 1'b0);
    push_blk({rnd64(), rnd64()}, 16, 1'b1);
    push_blk({rnd64(), rnd64()}, 0, 1'b1);
    push_blk({rnd64(), rnd64()}, 7, 1'b1);
    drain();

    // Decrypt with padding: full pad block, one pad byte, a corrupted pad, beats that are not full.
    cfg_write(acp_pkg::CFG_MODE, 64'd1);
    cfg_write(acp_pkg::CFG_PAD_EN, 64'd1);
    push_msg(0, 0, 1'b0);
    push_msg(1, 15, 1'b0);
    push_msg(0, 4, 1'b1);
    push_blk({rnd64(), rnd64()}, 15, 1'b0);
    push_blk({rnd64(), rnd64()}, 31, 1'b1);
    push_blk({rnd64(), rnd64()}, 0, 1'b1);
    drain();

    while (n_sent < 1350) begin
      for (int i = 0; i < 6; i++)
        cfg_write(3'(i), ($urandom_range(0, 9) == 0) ? '0 : rnd64());
      cfg_write(acp_pkg::CFG_MODE, 64'($urandom_range(0, 1)));
      cfg_write(acp_pkg::CFG_PAD_EN, 64'($urandom_range(0, 9) < 7));
      for (int m = 0; m < 15; m++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_blk({rnd64(), rnd64()}, 5'($urandom), 1'($urandom));
        end else begin
          nfull = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
          tail = (mode_r == MODE_ENC) ? $urandom_range(0, 16) : $urandom_range(0, 15);
          push_msg(nfull, tail, $urandom_range(0, 9) == 0);
        end
      end
      drain();
    end

    $display("%0d input beats in %0d messages, %0d result beats checked", n_sent, n_msgs,
             n_res);
    $display("%0d padding failures and %0d partial-block errors seen", n_pad_err, n_part_err);
    if (n_fail == 0) begin
      $display("[aes256_cbc_pkcs7_engine_top] OK");
    end else begin
      $display("[aes256_cbc_pkcs7_engine_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/acp_pkg.sv
src/acp_front.sv
src/acp_core.sv
src/aes256_cbc_pkcs7_engine_top.sv
test/aes256_cbc_pkcs7_engine_top_tb.sv
